// ===== hw/rtl/rau_pkg.sv =====
// shared types, constants and helper functions of the rational arithmetic unit
`default_nettype none
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int FIELD_W = 16;
   localparam int MAG_W = 2 * OPERAND_WIDTH;
   localparam int NUM_W = 34;
   localparam int DEN_W = 32;
   localparam int EXT_W = (MAG_W > NUM_W) ? MAG_W : NUM_W;
   localparam int OP_EXT_W = (OPERAND_WIDTH > FIELD_W) ? OPERAND_WIDTH : FIELD_W;
   localparam int CNT_W = $clog2(MAG_W + 1);

   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_SUB    = 3'd1,
      ACT_MUL    = 3'd2,
      ACT_DIV    = 3'd3,
      ACT_REDUCE = 3'd4,
      ACT_INC    = 3'd5,
      ACT_DEC    = 3'd6,
      ACT_CMP    = 3'd7
   } action_type;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
   localparam logic [1:0] ERR_DIV_ZERO = 2'd2;

   localparam logic [1:0] CMP_LESS    = 2'd0;
   localparam logic [1:0] CMP_EQUAL   = 2'd1;
   localparam logic [1:0] CMP_GREATER = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_GCD_GO,
      ST_GCD_WAIT,
      ST_DIVN_GO,
      ST_DIVN_WAIT,
      ST_DIVD_GO,
      ST_DIVD_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]          action;
      logic signed [15:0]  left_num;
      logic signed [15:0]  left_den;
      logic signed [15:0]  right_num;
      logic signed [15:0]  right_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] result_num;
      logic [DEN_W-1:0]        result_den;
      logic [1:0]              compare_result;
      logic [1:0]              error_code;
   } rsp_type;

   typedef struct packed {
      logic                     neg;
      logic [OPERAND_WIDTH-1:0] mag;
   } op_smag_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } wide_smag_type;

   typedef struct packed {
      logic start;
   } unit_ctrl_type;

   typedef struct packed {
      logic done;
   } unit_status_type;

   // two's complement field to sign and magnitude over OPERAND_WIDTH bits
   function automatic op_smag_type take_operand(logic [FIELD_W-1:0] raw);
      logic [OP_EXT_W-1:0]      wide;
      logic [OPERAND_WIDTH-1:0] v;
      op_smag_type              r;
      wide = OP_EXT_W'(raw);
      v = wide[OPERAND_WIDTH-1:0];
      r.neg = v[OPERAND_WIDTH-1];
      r.mag = r.neg ? (~v + OPERAND_WIDTH'(1)) : v;
      return r;
   endfunction

   function automatic wide_smag_type sm_add(wide_smag_type a, wide_smag_type b);
      wide_smag_type r;
      if (a.neg == b.neg) begin
         r.mag = a.mag + b.mag;
         r.neg = a.neg;
      end else if (a.mag >= b.mag) begin
         r.mag = a.mag - b.mag;
         r.neg = a.neg;
      end else begin
         r.mag = b.mag - a.mag;
         r.neg = b.neg;
      end
      if (r.mag == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rau_gcd.sv =====
// iterative binary gcd, one subtract or shift step per cycle
`default_nettype none
module rau_gcd import rau_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire unit_ctrl_type   ctrl,
   input  wire logic [MAG_W-1:0] a_in,
   input  wire logic [MAG_W-1:0] b_in,
   output unit_status_type      status,
   output logic [MAG_W-1:0]     gcd_out
);

   logic [MAG_W-1:0] a_ff, a_in_nx;
   logic [MAG_W-1:0] b_ff, b_in_nx;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      a_in_nx = a_ff;
      b_in_nx = b_ff;
      k_in = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         a_in_nx = a_in;
         b_in_nx = b_in;
         k_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            // common factor of two
            a_in_nx = a_ff >> 1;
            b_in_nx = b_ff >> 1;
            k_in = k_ff + CNT_W'(1);
         end else if (!a_ff[0]) begin
            a_in_nx = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in_nx = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in_nx = b_ff;
            b_in_nx = a_ff - b_ff;
         end else begin
            b_in_nx = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in_nx;
      b_ff <= b_in_nx;
      k_ff <= k_in;
   end

   assign status.done = done_ff;
   assign gcd_out = a_ff << k_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rau_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module rau_div import rau_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire unit_ctrl_type    ctrl,
   input  wire logic [MAG_W-1:0] dividend,
   input  wire logic [MAG_W-1:0] divisor,
   output unit_status_type       status,
   output logic [MAG_W-1:0]      quotient
);

   logic [MAG_W:0]   rem_ff, rem_in;
   logic [MAG_W-1:0] quo_ff, quo_in;
   logic [MAG_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MAG_W:0]   shifted;
   logic [MAG_W:0]   diff;

   always_comb begin
      shifted = {rem_ff[MAG_W-1:0], quo_ff[MAG_W-1]};
      diff = shifted - {1'b0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
         cnt_in = CNT_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // dividend bits leave the top as quotient bits enter the bottom
         if (!diff[MAG_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign status.done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit_top.sv =====
// steps from the accept cycle: accept, three multiply steps, add, gcd start, a gcd that takes
// one shift or subtract step per cycle, two divisions (numerator, then denominator), finish;
// error items go from accept straight to finish, compare and zero results from the add to finish
// throughput: one item at a time, the next beat is taken once the result sits in the output
// register; reset: synchronous, clears the sequencer and the result valid; no storage to clear
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type       state_ff, state_in;
   action_type      action_ff;
   op_smag_type     ln_ff, ld_ff, rn_ff, rd_ff;
   op_smag_type     ln_dec, ld_dec, rn_dec, rd_dec;
   wide_smag_type   p1_ff, p2_ff, den_ff, num_ff;
   wide_smag_type   mul_out, sum;
   logic [MAG_W-1:0] g_ff;
   logic [MAG_W-1:0] res_mag_ff;
   logic             res_neg_ff;
   logic [MAG_W-1:0] res_den_ff;
   logic [1:0]       cmp_ff;
   logic [1:0]       err_ff;
   logic [1:0]       err_dec;
   logic             uses_right;
   logic             req_accept;
   logic             rsp_load;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic [OPERAND_WIDTH-1:0] mx, my;
   logic             mneg;
   logic [MAG_W-1:0] prod;
   logic [1:0]       cmp_code;
   unit_ctrl_type    gcd_ctrl, div_ctrl;
   unit_status_type  gcd_st, div_st;
   logic [MAG_W-1:0] gcd_val;
   logic [MAG_W-1:0] div_quo;
   logic [MAG_W-1:0] div_dividend;
   logic [EXT_W-1:0] num_ext, num_wide, den_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // operand decode and input checks
   always_comb begin
      ln_dec = take_operand(req_data.left_num);
      ld_dec = take_operand(req_data.left_den);
      rn_dec = take_operand(req_data.right_num);
      rd_dec = take_operand(req_data.right_den);
      uses_right = !(req_data.action == ACT_REDUCE || req_data.action == ACT_INC ||
                     req_data.action == ACT_DEC);
      if (ld_dec.mag == '0 || (uses_right && rd_dec.mag == '0)) begin
         err_dec = ERR_ZERO_DEN;
      end else if (req_data.action == ACT_DIV && rn_dec.mag == '0) begin
         err_dec = ERR_DIV_ZERO;
      end else begin
         err_dec = ERR_NONE;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      mx = '0;
      my = '0;
      mneg = 1'b0;
      case (state_ff)
         ST_MUL0: begin
            mx = ln_ff.mag;
            case (action_ff) inside
               ACT_ADD, ACT_SUB, ACT_DIV: begin
                  my = rd_ff.mag;
                  mneg = ln_ff.neg ^ rd_ff.neg;
               end
               ACT_CMP: begin
                  my = rd_ff.mag;
                  mneg = ln_ff.neg ^ ld_ff.neg;
               end
               ACT_MUL: begin
                  my = rn_ff.mag;
                  mneg = ln_ff.neg ^ rn_ff.neg;
               end
               default: begin
                  my = OPERAND_WIDTH'(1);
                  mneg = ln_ff.neg;
               end
            endcase
         end
         ST_MUL1: begin
            // second term, already negated where it is subtracted
            case (action_ff)
               ACT_ADD: begin
                  mx = ld_ff.mag;
                  my = rn_ff.mag;
                  mneg = ld_ff.neg ^ rn_ff.neg;
               end
               ACT_SUB: begin
                  mx = ld_ff.mag;
                  my = rn_ff.mag;
                  mneg = !(ld_ff.neg ^ rn_ff.neg);
               end
               ACT_CMP: begin
                  mx = rn_ff.mag;
                  my = ld_ff.mag;
                  mneg = !(rn_ff.neg ^ rd_ff.neg);
               end
               ACT_INC: begin
                  mx = ld_ff.mag;
                  my = OPERAND_WIDTH'(1);
                  mneg = ld_ff.neg;
               end
               ACT_DEC: begin
                  mx = ld_ff.mag;
                  my = OPERAND_WIDTH'(1);
                  mneg = !ld_ff.neg;
               end
               default: begin
                  mx = '0;
               end
            endcase
         end
         ST_MUL2: begin
            mx = ld_ff.mag;
            case (action_ff) inside
               ACT_ADD, ACT_SUB, ACT_MUL: begin
                  my = rd_ff.mag;
                  mneg = ld_ff.neg ^ rd_ff.neg;
               end
               ACT_DIV: begin
                  my = rn_ff.mag;
                  mneg = ld_ff.neg ^ rn_ff.neg;
               end
               default: begin
                  my = OPERAND_WIDTH'(1);
                  mneg = ld_ff.neg;
               end
            endcase
         end
         default: begin
            mx = '0;
         end
      endcase
      prod = MAG_W'(mx) * MAG_W'(my);
      mul_out.mag = prod;
      mul_out.neg = mneg;
   end

   always_comb begin
      sum = sm_add(p1_ff, p2_ff);
      if (sum.mag == '0) begin
         cmp_code = CMP_EQUAL;
      end else if (sum.neg) begin
         cmp_code = CMP_LESS;
      end else begin
         cmp_code = CMP_GREATER;
      end
   end

   assign div_dividend = (state_ff == ST_DIVN_GO) ? num_ff.mag : den_ff.mag;

   // sequencer
   always_comb begin
      state_in = state_ff;
      gcd_ctrl.start = 1'b0;
      div_ctrl.start = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (err_dec != ERR_NONE) ? ST_FINISH : ST_MUL0;
            end
         end
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_SUM;
         ST_SUM: begin
            if (action_ff == ACT_CMP || sum.mag == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GCD_GO;
            end
         end
         ST_GCD_GO: begin
            gcd_ctrl.start = 1'b1;
            state_in = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (gcd_st.done) begin
               state_in = ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: begin
            div_ctrl.start = 1'b1;
            state_in = ST_DIVN_WAIT;
         end
         ST_DIVN_WAIT: begin
            if (div_st.done) begin
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: begin
            div_ctrl.start = 1'b1;
            state_in = ST_DIVD_WAIT;
         end
         ST_DIVD_WAIT: begin
            if (div_st.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept) begin
         action_ff <= action_type'(req_data.action);
         ln_ff <= ln_dec;
         ld_ff <= ld_dec;
         rn_ff <= rn_dec;
         rd_ff <= rd_dec;
         res_mag_ff <= '0;
         res_neg_ff <= 1'b0;
         res_den_ff <= MAG_W'(1);
         cmp_ff <= CMP_LESS;
         err_ff <= err_dec;
      end
      if (state_ff == ST_MUL0) begin
         p1_ff <= mul_out;
      end
      if (state_ff == ST_MUL1) begin
         p2_ff <= mul_out;
      end
      if (state_ff == ST_MUL2) begin
         den_ff <= mul_out;
      end
      if (state_ff == ST_SUM) begin
         num_ff <= sum;
         if (action_ff == ACT_CMP) begin
            cmp_ff <= cmp_code;
         end
      end
      if (state_ff == ST_GCD_WAIT && gcd_st.done) begin
         g_ff <= gcd_val;
      end
      if (state_ff == ST_DIVN_WAIT && div_st.done) begin
         res_mag_ff <= div_quo;
         res_neg_ff <= num_ff.neg ^ den_ff.neg;
      end
      if (state_ff == ST_DIVD_WAIT && div_st.done) begin
         res_den_ff <= div_quo;
      end
      if (rsp_load) begin
         rsp_data_ff.result_num <= num_wide[NUM_W-1:0];
         rsp_data_ff.result_den <= den_ext[DEN_W-1:0];
         rsp_data_ff.compare_result <= cmp_ff;
         rsp_data_ff.error_code <= err_ff;
      end
   end

   assign num_ext = EXT_W'(res_mag_ff);
   assign num_wide = res_neg_ff ? (EXT_W'(0) - num_ext) : num_ext;
   assign den_ext = EXT_W'(res_den_ff);

   rau_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (gcd_ctrl),
      .a_in    (num_ff.mag),
      .b_in    (den_ff.mag),
      .status  (gcd_st),
      .gcd_out (gcd_val)
   );

   rau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (g_ff),
      .status   (div_st),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall)
      else $error("no busy after accepted beat");

   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && (!rsp_valid_ff || !rsp_stall)) |=> (rsp_valid && !req_stall))
      else $error("finished result not presented");

   a_error_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code != ERR_NONE) |->
         (rsp_data.result_num == '0 && rsp_data.result_den == DEN_W'(1) &&
          rsp_data.compare_result == CMP_LESS))
      else $error("error beat carries a value");

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(gcd_ctrl.start && div_ctrl.start))
      else $error("gcd and divider started together");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench of the rational arithmetic unit: directed and random fractions against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import rau_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type expected_fractions[$];
   int      mismatch_count;
   int      idle_cycles;
   int      send_idle_pct;
   int      recv_stall_pct;

   rational_arithmetic_unit_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   typedef struct {
      logic        neg;
      logic [63:0] mag;
   } signed_mag;

   function automatic signed_mag to_signed_mag(logic [15:0] raw);
      signed_mag r;
      logic [OPERAND_WIDTH-1:0] v;
      v = raw[OPERAND_WIDTH-1:0];
      r.neg = v[OPERAND_WIDTH-1];
      r.mag = r.neg ? 64'(OPERAND_WIDTH'(~v + 1'b1)) : 64'(v);
      if (r.neg && r.mag == 0) r.mag = 64'd1 << (OPERAND_WIDTH - 1);
      return r;
   endfunction

   function automatic signed_mag mag_mul(signed_mag a, signed_mag b);
      signed_mag r;
      r.mag = a.mag * b.mag;
      r.neg = (r.mag != 0) && (a.neg != b.neg);
      return r;
   endfunction

   function automatic signed_mag mag_sum(signed_mag a, signed_mag b);
      signed_mag r;
      if (a.neg == b.neg) begin
         r.mag = a.mag + b.mag;
         r.neg = a.neg;
      end else if (a.mag >= b.mag) begin
         r.mag = a.mag - b.mag;
         r.neg = a.neg;
      end else begin
         r.mag = b.mag - a.mag;
         r.neg = b.neg;
      end
      if (r.mag == 0) r.neg = 1'b0;
      return r;
   endfunction

   function automatic signed_mag mag_negate(signed_mag a);
      if (a.mag != 0) a.neg = ~a.neg;
      return a;
   endfunction

   function automatic logic [63:0] common_divisor(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rsp_type reduced_fraction(signed_mag n, signed_mag d);
      rsp_type r;
      logic [63:0] g, nm, dm;
      r = '0;
      r.result_den = 1;
      if (n.mag == 0 || d.mag == 0) return r;
      g = common_divisor(n.mag, d.mag);
      nm = n.mag / g;
      dm = d.mag / g;
      r.result_num = NUM_W'((n.neg != d.neg) ? -nm : nm);
      r.result_den = DEN_W'(dm);
      return r;
   endfunction

   function automatic rsp_type predict_fraction(req_type q);
      signed_mag ln, ld, rn, rd, a, b;
      rsp_type r;
      action_type act;
      act = action_type'(q.action);
      ln = to_signed_mag(q.left_num);
      ld = to_signed_mag(q.left_den);
      rn = to_signed_mag(q.right_num);
      rd = to_signed_mag(q.right_den);
      r = '0;
      r.result_den = 1;
      if (ld.mag == 0 || (!(act inside {ACT_REDUCE, ACT_INC, ACT_DEC}) && rd.mag == 0)) begin
         r.error_code = ERR_ZERO_DEN;
         return r;
      end
      if (act == ACT_DIV && rn.mag == 0) begin
         r.error_code = ERR_DIV_ZERO;
         return r;
      end
      case (act)
         ACT_ADD: r = reduced_fraction(mag_sum(mag_mul(ln, rd), mag_mul(ld, rn)), mag_mul(ld, rd));
         ACT_SUB: r = reduced_fraction(mag_sum(mag_mul(ln, rd), mag_negate(mag_mul(ld, rn))),
                                       mag_mul(ld, rd));
         ACT_MUL: r = reduced_fraction(mag_mul(ln, rn), mag_mul(ld, rd));
         ACT_DIV: r = reduced_fraction(mag_mul(ln, rd), mag_mul(ld, rn));
         ACT_REDUCE: r = reduced_fraction(ln, ld);
         ACT_INC: r = reduced_fraction(mag_sum(ln, ld), ld);
         ACT_DEC: r = reduced_fraction(mag_sum(ln, mag_negate(ld)), ld);
         default: begin
            // bring both denominators positive before cross multiplying
            if (ld.neg) ln = mag_negate(ln);
            if (rd.neg) rn = mag_negate(rn);
            ld.neg = 1'b0;
            rd.neg = 1'b0;
            a = mag_mul(ln, rd);
            b = mag_mul(rn, ld);
            if (a.neg != b.neg) r.compare_result = a.neg ? CMP_LESS : CMP_GREATER;
            else if (a.mag == b.mag) r.compare_result = CMP_EQUAL;
            else if (!a.neg) r.compare_result = (a.mag < b.mag) ? CMP_LESS : CMP_GREATER;
            else r.compare_result = (a.mag > b.mag) ? CMP_LESS : CMP_GREATER;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // valid stays high after a beat so that back to back items need no second assignment
   task automatic send_fraction(req_type q);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_fractions.push_back(predict_fraction(q));
   endtask

   function automatic req_type make_item(action_type a, int ln, int ld, int rn, int rd);
      req_type q;
      q.action = a;
      q.left_num = 16'(ln);
      q.left_den = 16'(ld);
      q.right_num = 16'(rn);
      q.right_den = 16'(rd);
      return q;
   endfunction

   function automatic logic [15:0] random_operand();
      case ($urandom_range(5))
         0: return 16'($urandom_range(0, 12)) - 16'd6;
         1: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
         2: return 16'($urandom_range(0, 64) * ($urandom_range(1) ? 1 : -1));
         default: return 16'($urandom);
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fractions.size() == 0) begin
               report_mismatch("unexpected beat", 64'(rsp_data), 0);
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_data.result_num !== want.result_num)
                  report_mismatch("result_num", 64'(rsp_data.result_num), 64'(want.result_num));
               if (rsp_data.result_den !== want.result_den)
                  report_mismatch("result_den", 64'(rsp_data.result_den), 64'(want.result_den));
               if (rsp_data.compare_result !== want.compare_result)
                  report_mismatch("compare_result", 64'(rsp_data.compare_result),
                                  64'(want.compare_result));
               if (rsp_data.error_code !== want.error_code)
                  report_mismatch("error_code", 64'(rsp_data.error_code), 64'(want.error_code));
            end
         end
         rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL rational_arithmetic_unit_top");
            $finish;
         end
      end
   end

   task automatic test_directed();
      action_type a;
      send_fraction(make_item(ACT_ADD, 32767, -32768, -32768, 32767));
      send_fraction(make_item(ACT_SUB, -32768, -32768, 32767, -32768));
      send_fraction(make_item(ACT_MUL, -32768, 32767, -32768, -1));
      send_fraction(make_item(ACT_DIV, 1, 3, -2, 5));
      send_fraction(make_item(ACT_DIV, 5, 3, 0, 7));
      send_fraction(make_item(ACT_ADD, 1, 0, 1, 1));
      send_fraction(make_item(ACT_CMP, 1, 1, 1, 0));
      send_fraction(make_item(ACT_REDUCE, 6, 0, 1, 0));
      send_fraction(make_item(ACT_REDUCE, -6, -4, 0, 0));
      send_fraction(make_item(ACT_INC, 3, -3, 0, 0));
      send_fraction(make_item(ACT_DEC, 0, -32768, 0, 0));
      send_fraction(make_item(ACT_SUB, 1, 2, 2, 4));
      send_fraction(make_item(ACT_CMP, 1, 2, 2, 4));
      send_fraction(make_item(ACT_CMP, 1, -2, 1, 3));
      send_fraction(make_item(ACT_CMP, 2, 3, -1, -3));
      send_fraction(make_item(ACT_CMP, -32768, -32768, 32767, 32767));
      send_fraction(make_item(ACT_MUL, 0, 9, 5, -9));
      for (int i = 0; i < 8; i++) begin
         a = action_type'(i);
         send_fraction(make_item(a, 16'hffff, 16'h5555, 16'haaaa, 16'h0001));
      end
   endtask

   task automatic test_random(int count, int idle_pct, int stall_pct);
      req_type q;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         q.action = 3'($urandom_range(7));
         q.left_num = random_operand();
         q.left_den = ($urandom_range(19) == 0) ? 16'd0 : random_operand();
         q.right_num = random_operand();
         q.right_den = ($urandom_range(19) == 0) ? 16'd0 : random_operand();
         send_fraction(q);
      end
   endtask

   initial begin
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(400, 0, 0);
      test_random(400, 75, 0);
      test_random(400, 0, 75);
      test_random(400, 23, 23);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      while (expected_fractions.size() != 0) @(posedge clock);
      recv_stall_pct = 0;
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS rational_arithmetic_unit_top");
      end else begin
         $display("FAIL rational_arithmetic_unit_top");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_gcd.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arithmetic_unit_top.sv
tb/tb.sv
